>>> sv/ssdu_pkg.sv
package ssdu_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 64;
   localparam int SAMPLE_W = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TOO_FEW = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

endpackage

>>> sv/sample_standard_deviation_unit.sv
// channel   ports                                  transaction taken when
// request   start, busy, req_sample, req_last      start && !busy at rising edge
// response  rsp_strobe, rsp_std_dev, rsp_status    rsp_strobe high, one cycle only
//
// samples load one per cycle while busy is low; the sample marked last closes the set
// closing a set of n samples runs a bit-serial divide of the sum by n on the shared 64-bit
// subtractor, a second pass that reads the sample store one entry per cycle, a divide by n-1 on
// the same subtractor, then 32 square-root steps on that subtractor
// a set with fewer than two samples answers in the cycle after its last sample
// reset is synchronous and empties the set; the receiver cannot stall responses
module sample_standard_deviation_unit #(
   parameter int MAX_SAMPLES = ssdu_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ssdu_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              req_last,
   output logic                              rsp_strobe,
   output logic [ssdu_pkg::SAMPLE_W-1:0]     rsp_std_dev,
   output logic [ssdu_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int DW     = ssdu_pkg::SAMPLE_W;
   localparam int AW     = $clog2(MAX_SAMPLES);
   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = DW + AW;
   localparam int SUB_W  = 2 * DW;
   localparam int ACC_W  = SUB_W + AW;
   localparam int STEP_W = $clog2(ACC_W);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MEAN,
      ST_PASS,
      ST_VAR,
      ST_SQRT
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           count_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic                    ovf_ff;
   logic [SUB_W-1:0]        rem_ff;
   logic [ACC_W-1:0]        quo_ff;
   logic [SUB_W-1:0]        root_ff;
   logic [SUB_W-1:0]        bit_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [DW-1:0]           mean_ff;
   logic [CW-1:0]           issue_ff;
   logic                    rd_valid_ff;
   logic                    mag_valid_ff;
   logic                    sq_valid_ff;
   logic [DW-1:0]           rd_data_ff;
   logic [DW-1:0]           mag_ff;
   logic [SUB_W-1:0]        sq_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic                    rsp_strobe_ff;
   logic [DW-1:0]           rsp_std_dev_ff;
   ssdu_pkg::status_type    rsp_status_ff;

   logic [DW-1:0]           sample_store_mem [MAX_SAMPLES];

   logic                    accept;
   logic                    count_lt;
   logic [CW-1:0]           count_in;
   logic [SUM_W-1:0]        sum_in;
   logic                    ovf_in;
   logic [SUM_W-1:0]        sum_mag;
   logic [SUB_W-1:0]        trial;
   logic [SUB_W-1:0]        den;
   logic [SUB_W-1:0]        op_a;
   logic [SUB_W-1:0]        op_b;
   logic [SUB_W:0]          diff;
   logic                    ge;
   logic [SUB_W-1:0]        rem_in;
   logic [ACC_W-1:0]        quo_in;
   logic [SUB_W-1:0]        root_in;
   logic [DW-1:0]           mean_in;
   logic [SUB_W-1:0]        var_in;
   logic [DW:0]             dev;
   logic [DW-1:0]           mag_in;
   logic [SUB_W-1:0]        sq_in;
   logic                    issue_more;
   logic                    pass_done;

   assign busy        = (state_ff != ST_LOAD);
   assign accept      = start && !busy;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_std_dev = rsp_std_dev_ff;
   assign rsp_status  = rsp_status_ff;

   // set accumulation
   assign count_lt = (count_ff < CW'(MAX_SAMPLES));
   assign count_in = count_lt ? count_ff + CW'(1) : count_ff;
   assign sum_in   = count_lt ? sum_ff + {{(SUM_W-DW){req_sample[DW-1]}}, req_sample} : sum_ff;
   assign ovf_in   = ovf_ff || !count_lt;
   assign sum_mag  = sum_in[SUM_W-1] ? (~sum_in + SUM_W'(1)) : sum_in;

   // shared subtractor: restoring divider step or square-root step
   assign trial  = {rem_ff[SUB_W-2:0], quo_ff[ACC_W-1]};
   assign den    = (state_ff == ST_MEAN) ? SUB_W'(count_ff) : SUB_W'(count_ff - CW'(1));
   assign op_a   = (state_ff == ST_SQRT) ? rem_ff : trial;
   assign op_b   = (state_ff == ST_SQRT) ? (root_ff + bit_ff) : den;
   assign diff   = {1'b0, op_a} - {1'b0, op_b};
   assign ge     = !diff[SUB_W];
   assign rem_in = ge ? diff[SUB_W-1:0] : op_a;
   assign quo_in = {quo_ff[ACC_W-2:0], ge};
   assign root_in = ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

   assign mean_in = sum_ff[SUM_W-1] ? (~quo_in[DW-1:0] + DW'(1)) : quo_in[DW-1:0];
   assign var_in  = (|quo_in[ACC_W-1:SUB_W]) ? {SUB_W{1'b1}} : quo_in[SUB_W-1:0];

   // second pass datapath
   assign dev    = {rd_data_ff[DW-1], rd_data_ff} - {mean_ff[DW-1], mean_ff};
   assign mag_in = dev[DW] ? (~dev[DW-1:0] + DW'(1)) : dev[DW-1:0];
   assign sq_in  = SUB_W'(mag_ff) * SUB_W'(mag_ff);

   assign issue_more = (issue_ff != count_ff);
   assign pass_done  = !issue_more && !rd_valid_ff && !mag_valid_ff && !sq_valid_ff;

   always_ff @(posedge clock) begin
      if (accept && count_lt) begin
         sample_store_mem[count_ff[AW-1:0]] <= req_sample;
      end
      rd_data_ff <= sample_store_mem[issue_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         sum_ff        <= '0;
         ovf_ff        <= 1'b0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         mag_valid_ff  <= 1'b0;
         sq_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_valid_ff   <= (state_ff == ST_PASS) && issue_more;
         mag_valid_ff  <= rd_valid_ff;
         sq_valid_ff   <= mag_valid_ff;
         mag_ff        <= mag_in;
         sq_ff         <= sq_in;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (req_last && (count_in < CW'(2))) begin
                     rsp_strobe_ff  <= 1'b1;
                     rsp_std_dev_ff <= '0;
                     rsp_status_ff  <= ssdu_pkg::STATUS_TOO_FEW;
                     count_ff       <= '0;
                     sum_ff         <= '0;
                     ovf_ff         <= 1'b0;
                  end else begin
                     count_ff <= count_in;
                     sum_ff   <= sum_in;
                     ovf_ff   <= ovf_in;
                     if (req_last) begin
                        rem_ff   <= '0;
                        quo_ff   <= ACC_W'(sum_mag);
                        step_ff  <= STEP_W'(ACC_W - 1);
                        state_ff <= ST_MEAN;
                     end
                  end
               end
            end
            ST_MEAN: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  mean_ff  <= mean_in;
                  issue_ff <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_PASS;
               end
            end
            ST_PASS: begin
               if (issue_more) begin
                  issue_ff <= issue_ff + CW'(1);
               end
               if (sq_valid_ff) begin
                  acc_ff <= acc_ff + ACC_W'(sq_ff);
               end
               if (pass_done) begin
                  rem_ff   <= '0;
                  quo_ff   <= acc_ff;
                  step_ff  <= STEP_W'(ACC_W - 1);
                  state_ff <= ST_VAR;
               end
            end
            ST_VAR: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  rem_ff   <= var_in;
                  root_ff  <= '0;
                  bit_ff   <= SUB_W'(1) << (SUB_W - 2);
                  step_ff  <= STEP_W'(DW - 1);
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               rem_ff  <= rem_in;
               root_ff <= root_in;
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  rsp_strobe_ff  <= 1'b1;
                  rsp_std_dev_ff <= root_in[DW-1:0];
                  rsp_status_ff  <= ovf_ff ? ssdu_pkg::STATUS_DROPPED : ssdu_pkg::STATUS_OK;
                  count_ff       <= '0;
                  sum_ff         <= '0;
                  ovf_ff         <= 1'b0;
                  state_ff       <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_SQRT || (accept && req_last)))
      else $error("response without a closing set");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count above capacity");

   a_too_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ssdu_pkg::STATUS_TOO_FEW) |-> (rsp_std_dev == '0))
      else $error("too-few response with nonzero value");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff >= CW'(2)))
      else $error("computing on fewer than two samples");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (count_ff == '0 && !ovf_ff && !busy))
      else $error("set not cleared after response");
`endif

endmodule
